### rtl/dbdma_pkg.sv
// Shared types and constants of the block DMA controller.
// Item and result structs, mode and configuration codes, default parameters.
// No dependencies.
`timescale 1ns / 1ps

package dbdma_pkg;

  localparam int unsigned ChannelsDef   = 4;
  localparam int unsigned AddrBitsDef   = 16;
  localparam int unsigned SubregsPerCh  = 5;
  localparam int unsigned IrqVecBase    = 16;

  localparam logic [15:0] EnableRegAddrDef   = 16'd84;
  localparam logic [15:0] SubaddrRegAddrDef  = 16'd85;
  localparam logic [15:0] DataIncRegAddrDef  = 16'd86;
  localparam logic [15:0] DataNoincRegAddrDef = 16'd87;

  localparam logic [15:0] MaxWordsReset  = 16'd4096;
  localparam logic [4:0]  IrqVectorReset = 5'd30;

  localparam logic [1:0] ModeRegWr  = 2'd0;
  localparam logic [1:0] ModeTick   = 2'd1;
  localparam logic [1:0] ModeMemWr  = 2'd2;
  localparam logic [1:0] ModeMemRd  = 2'd3;

  localparam logic [1:0] CfgEnable   = 2'd0;
  localparam logic [1:0] CfgMaxWords = 2'd1;
  localparam logic [1:0] CfgIrqVec   = 2'd2;

  localparam logic [1:0] SubSrc = 2'd0;
  localparam logic [1:0] SubDst = 2'd1;
  localparam logic [1:0] SubCnt = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [15:0] write_value;
  } item_t;

  typedef struct packed {
    logic        claimed;
    logic [15:0] read_data;
    logic        irq_valid;
    logic [2:0]  irq_channel;
    logic [4:0]  irq_vector_out;
    logic [3:0]  irq_mask_bit;
    logic        last;
  } result_t;

endpackage

### rtl/dsp_block_dma_controller_unit.sv
// Top level of the multichannel block DMA controller.
// Depends on dbdma_pkg and dbdma_ram (data memory and channel register bank).
`timescale 1ns / 1ps

// Usage:
// - Command channel: item_i is taken at a rising edge with start_i high and busy_o low.
//   Modes: register write, tick, memory write, memory read.
// - Results appear on result_o for one cycle with done_o high; result_o.last marks the
//   final result of an item. The receiver cannot stall; every result must be taken.
// - Register writes, memory writes and memory reads give their result in the cycle after
//   acceptance and keep busy_o low, so one such item can be accepted every cycle.
// - A tick with the block enabled scans the channels, unarmed ones at one per cycle. Each
//   armed channel loads source, destination and count from the register bank in turn; a
//   valid transfer then runs through the single data memory read port and write port,
//   and a finish state retires it. After the last channel a closing scan state ends the
//   scan and the closing result comes in the cycle after it; busy_o stays high until
//   that cycle.
// - Interrupt results are held back one completion so the last one carries last = 1.
// - Configuration: cfg_we_i writes register cfg_idx_i (enable, max_words, irq_vector)
//   with no wait; write only while the block is idle.
// - Reset clears control state, the enable register, the pointer and armed channels;
//   the channel bank reads as zero until written. Data memory is undefined until written.

module dsp_block_dma_controller_unit #(
  parameter int unsigned CHANNELS     = dbdma_pkg::ChannelsDef,
  parameter int unsigned ADDR_BITS    = dbdma_pkg::AddrBitsDef,
  parameter logic [15:0] ENABLE_REG_ADDR     = dbdma_pkg::EnableRegAddrDef,
  parameter logic [15:0] SUBADDR_REG_ADDR    = dbdma_pkg::SubaddrRegAddrDef,
  parameter logic [15:0] DATA_INC_REG_ADDR   = dbdma_pkg::DataIncRegAddrDef,
  parameter logic [15:0] DATA_NOINC_REG_ADDR = dbdma_pkg::DataNoincRegAddrDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  dbdma_pkg::item_t   item_i,
  output logic               done_o,
  output dbdma_pkg::result_t result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  localparam int unsigned BankWords = CHANNELS * dbdma_pkg::SubregsPerCh;
  localparam int unsigned BankAw    = $clog2(BankWords);
  localparam int unsigned MemWords  = 2 ** ADDR_BITS;
  localparam int unsigned ChW       = $clog2(CHANNELS + 1);
  localparam int unsigned ChIdxW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StLoad   = 3'd2;
  localparam logic [2:0] StCopy   = 3'd3;
  localparam logic [2:0] StFinish = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        cfg_en_q;
  logic [15:0] max_words_q;
  logic [4:0]  irq_vec_q;

  logic [15:0]         enable_reg_q, enable_reg_d;
  logic [15:0]         subaddr_q, subaddr_d;
  logic [CHANNELS-1:0] armed_q, armed_d;
  logic [BankWords-1:0] sub_vld_q, sub_vld_d;
  logic                sub_rvld_q;

  logic [ChW-1:0] ch_q, ch_d;
  logic [1:0]     ld_q, ld_d;
  logic [15:0]    src_q, src_d, dst_q, dst_d;
  logic [15:0]    rd_rem_q, rd_rem_d, rd_addr_q, rd_addr_d, wr_addr_q, wr_addr_d;
  logic           wr_go_q, wr_go_d;
  logic           pend_q, pend_d;
  logic [ChW-1:0] pend_ch_q, pend_ch_d;

  logic               done_q, done_d;
  dbdma_pkg::result_t out_q, out_d;
  logic               rd_res_q, rd_res_d;

  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [15:0]          mem_wdata, mem_rdata, mem_rdata_eff;
  logic                 fwd_q;
  logic [15:0]          fwd_data_q;

  logic              sub_we, sub_re;
  logic [BankAw-1:0] sub_waddr, sub_raddr;
  logic [15:0]       sub_wdata, sub_rdata, sub_val;

  logic       accept;
  logic       claimed;
  logic [15:0] en_clr;
  logic [BankAw-1:0] ch_base;

  dbdma_ram #(
    .WIDTH (16),
    .DEPTH (MemWords)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dbdma_ram #(
    .WIDTH (16),
    .DEPTH (BankWords)
  ) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (sub_we),
    .waddr_i (sub_waddr),
    .wdata_i (sub_wdata),
    .re_i    (sub_re),
    .raddr_i (sub_raddr),
    .rdata_o (sub_rdata)
  );

  assign accept        = start_i && (state_q == StIdle);
  assign busy_o        = (state_q != StIdle);
  assign mem_rdata_eff = fwd_q ? fwd_data_q : mem_rdata;
  assign sub_val       = sub_rvld_q ? sub_rdata : 16'd0;
  assign claimed       = cfg_en_q && ((item_i.address == ENABLE_REG_ADDR) ||
                                      (item_i.address == SUBADDR_REG_ADDR) ||
                                      (item_i.address == DATA_INC_REG_ADDR) ||
                                      (item_i.address == DATA_NOINC_REG_ADDR));
  assign ch_base       = BankAw'(ch_q) * BankAw'(dbdma_pkg::SubregsPerCh);
  assign en_clr        = enable_reg_q & ~(16'd1 << ch_q);

  always_comb begin
    state_d      = state_q;
    enable_reg_d = enable_reg_q;
    subaddr_d    = subaddr_q;
    armed_d      = armed_q;
    sub_vld_d    = sub_vld_q;
    ch_d         = ch_q;
    ld_d         = ld_q;
    src_d        = src_q;
    dst_d        = dst_q;
    rd_rem_d     = rd_rem_q;
    rd_addr_d    = rd_addr_q;
    wr_addr_d    = wr_addr_q;
    wr_go_d      = 1'b0;
    pend_d       = pend_q;
    pend_ch_d    = pend_ch_q;
    done_d       = 1'b0;
    out_d        = '0;
    rd_res_d     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = item_i.address[ADDR_BITS-1:0];
    mem_wdata    = item_i.write_value;
    mem_re       = 1'b0;
    mem_raddr    = item_i.address[ADDR_BITS-1:0];
    sub_we       = 1'b0;
    sub_waddr    = subaddr_q[BankAw-1:0];
    sub_wdata    = item_i.write_value;
    sub_re       = 1'b0;
    sub_raddr    = ch_base;

    case (state_q)
      StIdle: begin
        if (accept) begin
          out_d.last = 1'b1;
          case (item_i.mode)
            dbdma_pkg::ModeRegWr: begin
              done_d        = 1'b1;
              out_d.claimed = claimed;
              mem_we        = claimed;
              if (claimed) begin
                if (item_i.address == ENABLE_REG_ADDR) begin
                  enable_reg_d = item_i.write_value;
                  armed_d = armed_q |
                            (item_i.write_value[CHANNELS-1:0] & ~enable_reg_q[CHANNELS-1:0]);
                end else if (item_i.address == SUBADDR_REG_ADDR) begin
                  subaddr_d = item_i.write_value;
                end else begin
                  if (subaddr_q < 16'(BankWords)) begin
                    sub_we = 1'b1;
                    sub_vld_d[subaddr_q[BankAw-1:0]] = 1'b1;
                  end
                  if (item_i.address == DATA_INC_REG_ADDR) begin
                    subaddr_d = subaddr_q + 16'd1;
                  end
                end
              end
            end
            dbdma_pkg::ModeTick: begin
              if (cfg_en_q) begin
                out_d.last = 1'b0;
                ch_d       = '0;
                pend_d     = 1'b0;
                state_d    = StScan;
              end else begin
                done_d = 1'b1;
              end
            end
            dbdma_pkg::ModeMemWr: begin
              done_d = 1'b1;
              mem_we = 1'b1;
            end
            default: begin
              done_d   = 1'b1;
              mem_re   = 1'b1;
              rd_res_d = 1'b1;
            end
          endcase
        end
      end

      StScan: begin
        if (ch_q == ChW'(CHANNELS)) begin
          done_d     = 1'b1;
          out_d.last = 1'b1;
          if (pend_q) begin
            out_d.irq_valid      = 1'b1;
            out_d.irq_channel    = 3'(pend_ch_q);
            out_d.irq_vector_out = irq_vec_q;
            out_d.irq_mask_bit   = irq_vec_q[3:0];
          end
          state_d = StIdle;
        end else if (armed_q[ch_q[ChIdxW-1:0]]) begin
          armed_d[ch_q[ChIdxW-1:0]] = 1'b0;
          sub_re    = 1'b1;
          sub_raddr = ch_base + BankAw'(dbdma_pkg::SubSrc);
          ld_d      = 2'd1;
          state_d   = StLoad;
        end else begin
          ch_d = ch_q + ChW'(1);
        end
      end

      StLoad: begin
        ld_d = ld_q + 2'd1;
        if (ld_q == 2'd1) begin
          src_d     = sub_val;
          sub_re    = 1'b1;
          sub_raddr = ch_base + BankAw'(dbdma_pkg::SubDst);
        end else if (ld_q == 2'd2) begin
          dst_d     = sub_val;
          sub_re    = 1'b1;
          sub_raddr = ch_base + BankAw'(dbdma_pkg::SubCnt);
        end else begin
          if ((sub_val == 16'd0) || (sub_val > max_words_q)) begin
            ch_d    = ch_q + ChW'(1);
            state_d = StScan;
          end else begin
            rd_rem_d  = sub_val;
            rd_addr_d = src_q;
            wr_addr_d = dst_q;
            state_d   = StCopy;
          end
        end
      end

      StCopy: begin
        if (rd_rem_q != 16'd0) begin
          mem_re    = 1'b1;
          mem_raddr = rd_addr_q[ADDR_BITS-1:0];
          rd_addr_d = rd_addr_q + 16'd1;
          rd_rem_d  = rd_rem_q - 16'd1;
          wr_go_d   = 1'b1;
        end
        if (wr_go_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q[ADDR_BITS-1:0];
          mem_wdata = mem_rdata_eff;
          wr_addr_d = wr_addr_q + 16'd1;
        end
        if ((rd_rem_q == 16'd0) && !wr_go_q) begin
          state_d = StFinish;
        end
      end

      StFinish: begin
        sub_we    = 1'b1;
        sub_waddr = ch_base + BankAw'(dbdma_pkg::SubCnt);
        sub_wdata = 16'd0;
        sub_vld_d[ch_base + BankAw'(dbdma_pkg::SubCnt)] = 1'b1;
        enable_reg_d = en_clr;
        mem_we    = 1'b1;
        mem_waddr = ENABLE_REG_ADDR[ADDR_BITS-1:0];
        mem_wdata = en_clr;
        if (pend_q) begin
          done_d               = 1'b1;
          out_d.irq_valid      = 1'b1;
          out_d.irq_channel    = 3'(pend_ch_q);
          out_d.irq_vector_out = irq_vec_q;
          out_d.irq_mask_bit   = irq_vec_q[3:0];
        end
        pend_d    = 1'b1;
        pend_ch_d = ch_q;
        ch_d      = ch_q + ChW'(1);
        state_d   = StScan;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    result_o = out_q;
    if (rd_res_q) begin
      result_o.read_data = mem_rdata_eff;
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cfg_en_q     <= 1'b0;
      max_words_q  <= dbdma_pkg::MaxWordsReset;
      irq_vec_q    <= dbdma_pkg::IrqVectorReset;
      enable_reg_q <= '0;
      subaddr_q    <= '0;
      armed_q      <= '0;
      sub_vld_q    <= '0;
      sub_rvld_q   <= 1'b0;
      ch_q         <= '0;
      ld_q         <= '0;
      wr_go_q      <= 1'b0;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
      rd_res_q     <= 1'b0;
      fwd_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      enable_reg_q <= enable_reg_d;
      subaddr_q    <= subaddr_d;
      armed_q      <= armed_d;
      sub_vld_q    <= sub_vld_d;
      if (sub_re) begin
        sub_rvld_q <= sub_vld_q[sub_raddr];
      end
      ch_q     <= ch_d;
      ld_q     <= ld_d;
      wr_go_q  <= wr_go_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      rd_res_q <= rd_res_d;
      fwd_q    <= mem_re && mem_we && (mem_raddr == mem_waddr);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dbdma_pkg::CfgEnable:   cfg_en_q    <= cfg_wdata_i[0];
          dbdma_pkg::CfgMaxWords: max_words_q <= cfg_wdata_i;
          dbdma_pkg::CfgIrqVec:   irq_vec_q   <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    dst_q      <= dst_d;
    rd_rem_q   <= rd_rem_d;
    rd_addr_q  <= rd_addr_d;
    wr_addr_q  <= wr_addr_d;
    pend_ch_q  <= pend_ch_d;
    out_q      <= out_d;
    fwd_data_q <= mem_wdata;
  end

endmodule

### rtl/dbdma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the data memory and the channel register bank. No dependencies.
`timescale 1ns / 1ps

module dbdma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/dma_result_checker.sv
// Result checker for the block DMA controller: predicts every result of each accepted item
// and compares the result channel against it field by field.
// Depends on dbdma_pkg for the item, result and code definitions.
`timescale 1ns / 1ps

module dma_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  dbdma_pkg::item_t   item_i,
  input  logic               done_i,
  input  dbdma_pkg::result_t result_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  localparam int unsigned BankWords = dbdma_pkg::ChannelsDef * dbdma_pkg::SubregsPerCh;

  logic [15:0] data_mem [65536];
  logic [15:0] sub_regs [BankWords];
  logic [15:0] chan_en_reg;
  logic [15:0] sub_ptr;
  logic [dbdma_pkg::ChannelsDef-1:0] armed;

  logic        blk_enable;
  logic [15:0] max_words_q;
  logic [4:0]  irq_vec_q;

  dbdma_pkg::result_t expected_results [$];
  dbdma_pkg::result_t oldest;

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("%0t ns: result mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic bit apply_reg_write(input logic [15:0] addr, input logic [15:0] val);
    logic [15:0] prev;
    if (!blk_enable) return 1'b0;
    case (addr)
      dbdma_pkg::EnableRegAddrDef: begin
        prev = chan_en_reg;
        chan_en_reg = val;
        for (int c = 0; c < dbdma_pkg::ChannelsDef; c++) begin
          if (val[c] && !prev[c]) armed[c] = 1'b1;
        end
      end
      dbdma_pkg::SubaddrRegAddrDef: sub_ptr = val;
      dbdma_pkg::DataIncRegAddrDef, dbdma_pkg::DataNoincRegAddrDef: begin
        if (sub_ptr < BankWords) sub_regs[sub_ptr] = val;
        if (addr == dbdma_pkg::DataIncRegAddrDef) sub_ptr = sub_ptr + 16'd1;
      end
      default: return 1'b0;
    endcase
    data_mem[addr] = val;
    return 1'b1;
  endfunction

  // Hold each completion back one step so the final one carries last.
  task automatic predict_tick();
    dbdma_pkg::result_t held;
    dbdma_pkg::result_t irq;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] cnt;
    int base;
    held = '0;
    if (blk_enable) begin
      for (int c = 0; c < dbdma_pkg::ChannelsDef; c++) begin
        if (!armed[c]) continue;
        base = c * dbdma_pkg::SubregsPerCh;
        src = sub_regs[base + dbdma_pkg::SubSrc];
        dst = sub_regs[base + dbdma_pkg::SubDst];
        cnt = sub_regs[base + dbdma_pkg::SubCnt];
        armed[c] = 1'b0;
        if (cnt == 16'd0 || cnt > max_words_q) continue;
        for (int i = 0; i < int'(cnt); i++) data_mem[16'(dst + i)] = data_mem[16'(src + i)];
        sub_regs[base + dbdma_pkg::SubCnt] = 16'd0;
        chan_en_reg[c] = 1'b0;
        data_mem[dbdma_pkg::EnableRegAddrDef] = chan_en_reg;
        irq = '0;
        irq.irq_valid = 1'b1;
        irq.irq_channel = 3'(c);
        irq.irq_vector_out = irq_vec_q;
        irq.irq_mask_bit = 4'(irq_vec_q - 5'(dbdma_pkg::IrqVecBase));
        if (held.irq_valid) expected_results.push_back(held);
        held = irq;
      end
    end
    held.last = 1'b1;
    expected_results.push_back(held);
  endtask

  task automatic predict_item(input dbdma_pkg::item_t it);
    dbdma_pkg::result_t r;
    r = '0;
    r.last = 1'b1;
    case (it.mode)
      dbdma_pkg::ModeRegWr: begin
        r.claimed = apply_reg_write(it.address, it.write_value);
        expected_results.push_back(r);
      end
      dbdma_pkg::ModeTick: predict_tick();
      dbdma_pkg::ModeMemWr: begin
        data_mem[it.address] = it.write_value;
        expected_results.push_back(r);
      end
      dbdma_pkg::ModeMemRd: begin
        r.read_data = data_mem[it.address];
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (sub_regs[k]) sub_regs[k] = 16'd0;
      chan_en_reg = 16'd0;
      sub_ptr = 16'd0;
      armed = '0;
      blk_enable = 1'b0;
      max_words_q = dbdma_pkg::MaxWordsReset;
      irq_vec_q = dbdma_pkg::IrqVectorReset;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0h with nothing pending", result_i));
        end else begin
          oldest = expected_results.pop_front();
          check_field("claimed", result_i.claimed, oldest.claimed);
          check_field("read_data", result_i.read_data, oldest.read_data);
          check_field("irq_valid", result_i.irq_valid, oldest.irq_valid);
          check_field("irq_channel", result_i.irq_channel, oldest.irq_channel);
          check_field("irq_vector_out", result_i.irq_vector_out, oldest.irq_vector_out);
          check_field("irq_mask_bit", result_i.irq_mask_bit, oldest.irq_mask_bit);
          check_field("last", result_i.last, oldest.last);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dbdma_pkg::CfgEnable:   blk_enable = cfg_wdata_i[0];
          dbdma_pkg::CfgMaxWords: max_words_q = cfg_wdata_i;
          dbdma_pkg::CfgIrqVec:   irq_vec_q = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) predict_item(item_i);
      pending_o = expected_results.size();
    end
  end

endmodule

### tb/tb_dsp_block_dma_controller_unit.sv
// Testbench top for the block DMA controller: preloads a data memory window, drives directed
// and random register, tick and memory items over several configurations, gives the verdict.
// Depends on dbdma_pkg, the DUT and dma_result_checker.
`timescale 1ns / 1ps

module tb_dsp_block_dma_controller_unit;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned PhaseItems = 28;
  localparam logic [15:0] WinBase    = 16'hffe0;
  localparam int unsigned WinWords   = 96;
  localparam int unsigned SrcSpan    = 64;
  localparam int unsigned MaxCount   = 32;
  localparam int unsigned SafeVal    = 31;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  dbdma_pkg::item_t   item_i = '0;
  logic               done_o;
  dbdma_pkg::result_t result_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = dbdma_pkg::CfgEnable;
  logic [15:0]        cfg_wdata_i = 16'd0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned target;
  bit          idle_on = 1'b0;
  logic [15:0] cur_max = dbdma_pkg::MaxWordsReset;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  dsp_block_dma_controller_unit dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .item_i,
    .done_o,
    .result_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  dma_result_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i(busy_o),
    .item_i,
    .done_i(done_o),
    .result_i(result_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .pending_o(pending),
    .fail_count_o(mismatches)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [15:0] addr,
                           input logic [15:0] val);
    dbdma_pkg::item_t it;
    if (idle_on && $urandom_range(99) < 31) begin
      @(negedge clk_i);
      it.mode = 2'($urandom);
      it.address = 16'($urandom);
      it.write_value = 16'($urandom);
      start_i <= 1'b0;
      item_i <= it;
      repeat ($urandom_range(1)) @(negedge clk_i);
    end
    it.mode = mode;
    it.address = addr;
    it.write_value = val;
    @(negedge clk_i);
    item_i <= it;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Drop start and wait until every expected result is back.
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_config(input logic en, input logic [15:0] maxw, input logic [4:0] vec);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= dbdma_pkg::CfgEnable;
    cfg_wdata_i <= 16'(en);
    @(negedge clk_i);
    cfg_idx_i <= dbdma_pkg::CfgMaxWords;
    cfg_wdata_i <= maxw;
    @(negedge clk_i);
    cfg_idx_i <= dbdma_pkg::CfgIrqVec;
    cfg_wdata_i <= 16'(vec);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_max = maxw;
  endtask

  // Keep every copy inside the preloaded window, across the 16-bit wrap.
  function automatic logic [15:0] pick_addr();
    return WinBase + 16'($urandom_range(SrcSpan - 1));
  endfunction

  function automatic logic [15:0] win_addr();
    return WinBase + 16'($urandom_range(WinWords - 1));
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 25 && cur_max < 16'(MaxCount)) begin
      return 16'($urandom_range(MaxCount, int'(cur_max) + 1));
    end
    return 16'($urandom_range(MaxCount, 1));
  endfunction

  task automatic program_channel(input int c, input logic [15:0] src, input logic [15:0] dst,
                                 input logic [15:0] cnt);
    send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::SubaddrRegAddrDef,
              16'(c * dbdma_pkg::SubregsPerCh));
    send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef, src);
    send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef, dst);
    send_item(dbdma_pkg::ModeRegWr, $urandom_range(1) ? dbdma_pkg::DataIncRegAddrDef :
              dbdma_pkg::DataNoincRegAddrDef, cnt);
    if ($urandom_range(1)) begin
      send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef,
                16'($urandom_range(SafeVal)));
      send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef,
                16'($urandom_range(SafeVal)));
    end
  endtask

  task automatic copy_burst();
    logic [3:0]  chans;
    logic [15:0] en_val;
    chans = 4'($urandom_range(15, 1));
    for (int c = 0; c < dbdma_pkg::ChannelsDef; c++) begin
      if (chans[c]) program_channel(c, pick_addr(), pick_addr(), pick_count());
    end
    if ($urandom_range(1)) send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef, 16'd0);
    en_val = (16'($urandom) & 16'hfff0) | 16'(chans);
    send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef, en_val);
    send_item(dbdma_pkg::ModeTick, 16'($urandom), 16'($urandom));
    if ($urandom_range(3) == 0) send_item(dbdma_pkg::ModeTick, 16'($urandom), 16'($urandom));
    send_item(dbdma_pkg::ModeMemRd, win_addr(), 16'($urandom));
  endtask

  task automatic stray_item();
    logic [1:0]  mode;
    logic [15:0] addr;
    logic [15:0] val;
    int unsigned r;
    mode = 2'($urandom);
    r = $urandom_range(99);
    if (r < 50) addr = dbdma_pkg::EnableRegAddrDef + 16'($urandom_range(3));
    else if (r < 60) addr = $urandom_range(1) ? dbdma_pkg::EnableRegAddrDef - 16'd1 :
                                                dbdma_pkg::DataNoincRegAddrDef + 16'd1;
    else addr = 16'($urandom);
    val = 16'($urandom);
    if (addr == dbdma_pkg::SubaddrRegAddrDef && $urandom_range(1)) val = 16'($urandom_range(24));
    if (mode == dbdma_pkg::ModeRegWr && (addr == dbdma_pkg::DataIncRegAddrDef ||
                                         addr == dbdma_pkg::DataNoincRegAddrDef)) begin
      val = 16'($urandom_range(SafeVal));
    end
    if (mode == dbdma_pkg::ModeMemRd) addr = win_addr();
    send_item(mode, addr, val);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int a = 0; a < int'(WinWords); a++) begin
      send_item(dbdma_pkg::ModeMemWr, WinBase + 16'(a), 16'($urandom));
    end

    send_item(dbdma_pkg::ModeTick, 16'hffff, 16'hffff);
    send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef, 16'hffff);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      idle_on = (p != 3);
      case (p)
        0: set_config(1'b1, dbdma_pkg::MaxWordsReset, dbdma_pkg::IrqVectorReset);
        1: set_config(1'b1, 16'hffff, 5'd31);
        2: set_config(1'b1, 16'd16, 5'd16);
        3: set_config(1'b0, 16'd1, 5'd20);
        4: set_config(1'b1, 16'd0, 5'd0);
        5: set_config(1'b1, 16'd1, 5'd15);
        default: set_config(1'b1, 16'($urandom_range(4096, 2)), 5'($urandom));
      endcase
      if (p == 0) begin
        send_item(dbdma_pkg::ModeMemWr, 16'h0000, 16'hffff);
        send_item(dbdma_pkg::ModeMemWr, 16'hffff, 16'h0000);
        send_item(dbdma_pkg::ModeMemRd, 16'h0000, 16'h0000);
        send_item(dbdma_pkg::ModeMemRd, 16'hffff, 16'hffff);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef - 16'd1, 16'h1234);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataNoincRegAddrDef + 16'd1, 16'h4321);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::SubaddrRegAddrDef, 16'd0);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef, 16'd65530);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef, 16'd100);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef, 16'd10);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataNoincRegAddrDef, 16'hffff);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::SubaddrRegAddrDef,
                  16'(dbdma_pkg::ChannelsDef * dbdma_pkg::SubregsPerCh));
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef, 16'habcd);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::SubaddrRegAddrDef, 16'hffff);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataIncRegAddrDef, 16'h1234);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::DataNoincRegAddrDef, 16'd65530);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef, 16'h000f);
        send_item(dbdma_pkg::ModeTick, 16'd0, 16'd0);
        send_item(dbdma_pkg::ModeMemRd, 16'd109, 16'd0);
        send_item(dbdma_pkg::ModeMemWr, dbdma_pkg::EnableRegAddrDef, 16'h00ff);
        send_item(dbdma_pkg::ModeMemRd, dbdma_pkg::EnableRegAddrDef, 16'd0);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef, 16'h0001);
        send_item(dbdma_pkg::ModeTick, 16'd0, 16'd0);
      end
      if (p == 1) begin
        for (int c = 0; c < dbdma_pkg::ChannelsDef; c++) begin
          program_channel(c, pick_addr(), pick_addr(),
                          c == 2 ? 16'(MaxCount) : 16'($urandom_range(16, 1)));
        end
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef, 16'd0);
        send_item(dbdma_pkg::ModeRegWr, dbdma_pkg::EnableRegAddrDef, 16'h000f);
        send_item(dbdma_pkg::ModeTick, 16'd0, 16'd0);
      end
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if (p == 1 || $urandom_range(99) < 60) copy_burst();
        else stray_item();
      end
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dbdma_pkg.sv
rtl/dbdma_ram.sv
rtl/dsp_block_dma_controller_unit.sv
tb/dma_result_checker.sv
tb/tb_dsp_block_dma_controller_unit.sv
